[sv/hcfq_pkg.sv]
package hcfq_pkg;

  // capacity of the sorting chain, one record per cell
  localparam int MAX_TRACKS = 64;
  localparam int CNT_W      = $clog2(MAX_TRACKS + 1);
  localparam int SEQ_W      = $clog2(MAX_TRACKS);
  localparam int RANK_W     = 6;
  localparam int MODE_W     = 2;

  // sort mode codes (code 3 behaves as quality only)
  localparam logic [MODE_W-1:0] MODE_HITS    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STATION = 2'd1;
  localparam logic [MODE_W-1:0] MODE_QUALITY = 2'd2;

  typedef struct packed {
    logic [15:0] tag;
    logic [5:0]  hits;
    logic [4:0]  station;
    logic [23:0] chi;
    logic [7:0]  ndf;
  } trk_t;

  // arrival position within the set breaks ties on equal keys
  typedef struct packed {
    logic             valid;
    logic [SEQ_W-1:0] seq;
    trk_t             rec;
  } slot_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SETTLE,
    ST_DRAIN
  } state_e;

  // a strictly better fit than b on chi2/ndf, zero ndf ranks worst
  function automatic logic quality_before(trk_t a, trk_t b);
    logic [31:0] prod_a;
    logic [31:0] prod_b;
    prod_a = {8'd0, a.chi} * {24'd0, b.ndf};
    prod_b = {8'd0, b.chi} * {24'd0, a.ndf};
    if (a.ndf == 8'd0) begin
      return 1'b0;
    end else if (b.ndf == 8'd0) begin
      return 1'b1;
    end
    return prod_a < prod_b;
  endfunction

  // a strictly ahead of b under the selected mode
  function automatic logic ranks_before(trk_t a, trk_t b, logic [MODE_W-1:0] mode);
    logic res;
    res = quality_before(a, b);
    case (mode)
      MODE_HITS: begin
        if (a.hits != b.hits) res = a.hits > b.hits;
      end
      MODE_STATION: begin
        if (a.station != b.station) res = a.station > b.station;
      end
      default: begin
        res = quality_before(a, b);
      end
    endcase
    return res;
  endfunction

  // a ahead of b: better keys, or equal keys and earlier arrival
  function automatic logic slot_ahead(slot_t a, slot_t b, logic [MODE_W-1:0] mode);
    logic fwd;
    logic rev;
    fwd = ranks_before(a.rec, b.rec, mode);
    rev = ranks_before(b.rec, a.rec, mode);
    return fwd || (!rev && (a.seq < b.seq));
  endfunction

endpackage

[sv/hcfq_cell.sv]
module hcfq_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [hcfq_pkg::MODE_W-1:0] mode_i,
  input  hcfq_pkg::slot_t           in_i,
  input  logic                      shift_i,
  input  hcfq_pkg::slot_t           below_i,
  output hcfq_pkg::slot_t           held_o,
  output hcfq_pkg::slot_t           pass_o
);

  hcfq_pkg::slot_t held_q, held_d;
  hcfq_pkg::slot_t pass_q, pass_d;

  // keep the better record, hand the worse one on; on shift take the record held below
  always_comb begin
    held_d       = held_q;
    pass_d       = in_i;
    pass_d.valid = 1'b0;
    if (shift_i) begin
      held_d = below_i;
    end else if (in_i.valid) begin
      if (!held_q.valid) begin
        held_d = in_i;
      end else if (hcfq_pkg::slot_ahead(in_i, held_q, mode_i)) begin
        held_d = in_i;
        pass_d = held_q;
      end else begin
        pass_d = in_i;
      end
    end
  end

  // held and handed-on records
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      pass_q <= '0;
    end else begin
      held_q <= held_d;
      pass_q <= pass_d;
    end
  end

  assign held_o = held_q;
  assign pass_o = pass_q;

endmodule

[sv/hit_count_then_fit_quality_sort_top.sv]
// channel   direction  handshake                      payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: tag, hits, station, chi2, ndf; tlast
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: tag, rank; tuser: overflow; tlast
// cfg       in         cfg_valid_i / cfg_ready_o      sort mode, 2 bits
//
// tracks load at one per cycle into a chain of MAX_TRACKS insertion cells
// after the last track the chain settles until no cell hands a record on,
// that is until the last handed-on record has reached its cell
// results then leave one per cycle from the head cell through an output register
// a stalled output holds the chain; input is taken again once the chain is empty
// reset empties the chain and sets sort mode to hits then chi2/ndf
module hit_count_then_fit_quality_sort_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // tag[15:0], hits[21:16], station[26:22], chi2[50:27], ndf[58:51]
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // sorted tag[15:0], rank[21:16]
  output logic        m_axis_tuser,   // overflow seen[0]
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i      // sort mode[1:0]
);

  localparam int N = hcfq_pkg::MAX_TRACKS;

  hcfq_pkg::state_e state_q, state_d;

  logic [hcfq_pkg::MODE_W-1:0] mode_q;
  logic [hcfq_pkg::CNT_W-1:0]  count_q;
  logic                        ovf_q;
  logic [hcfq_pkg::RANK_W-1:0] rank_q;

  logic                        out_valid_q;
  logic [15:0]                 out_tag_q;
  logic [hcfq_pkg::RANK_W-1:0] out_rank_q;
  logic                        out_ovf_q;
  logic                        out_last_q;

  hcfq_pkg::slot_t cell_in [N];
  hcfq_pkg::slot_t below   [N];
  hcfq_pkg::slot_t held    [N];
  hcfq_pkg::slot_t pass    [N];
  logic [N-1:0]    pass_valid;

  logic in_xact, store_en, shift, drain_done, settled;

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= hcfq_pkg::MODE_HITS;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  // input transaction and injection at the chain head
  assign in_xact  = s_axis_tvalid && s_axis_tready;
  assign store_en = in_xact && (count_q < hcfq_pkg::CNT_W'(N));

  // chain of cells
  for (genvar k = 0; k < N; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_in[k] = {store_en, count_q[hcfq_pkg::SEQ_W-1:0],
                           s_axis_tdata[15:0], s_axis_tdata[21:16], s_axis_tdata[26:22],
                           s_axis_tdata[50:27], s_axis_tdata[58:51]};
    end else begin : g_link
      assign cell_in[k] = pass[k-1];
    end
    if (k < N - 1) begin : g_below
      assign below[k] = held[k+1];
    end else begin : g_end
      assign below[k] = '0;
    end
    assign pass_valid[k] = pass[k].valid;

    hcfq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .mode_i  (mode_q),
      .in_i    (cell_in[k]),
      .shift_i (shift),
      .below_i (below[k]),
      .held_o  (held[k]),
      .pass_o  (pass[k])
    );
  end

  assign settled = ~|pass_valid;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      hcfq_pkg::ST_LOAD: begin
        if (in_xact && s_axis_tlast) state_d = hcfq_pkg::ST_SETTLE;
      end
      hcfq_pkg::ST_SETTLE: begin
        if (settled) state_d = hcfq_pkg::ST_DRAIN;
      end
      hcfq_pkg::ST_DRAIN: begin
        if (!held[0].valid) state_d = hcfq_pkg::ST_LOAD;
      end
      default: begin
        state_d = hcfq_pkg::ST_LOAD;
      end
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    shift         = 1'b0;
    drain_done    = 1'b0;
    case (state_q)
      hcfq_pkg::ST_LOAD: begin
        s_axis_tready = 1'b1;
      end
      hcfq_pkg::ST_DRAIN: begin
        shift      = held[0].valid && (!out_valid_q || m_axis_tready);
        drain_done = !held[0].valid;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hcfq_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // set bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      rank_q  <= '0;
    end else begin
      if (drain_done) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
        rank_q  <= '0;
      end else begin
        if (store_en) count_q <= count_q + 1'b1;
        if (in_xact && !store_en) ovf_q <= 1'b1;
        if (shift) rank_q <= rank_q + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (shift) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift) begin
      out_tag_q  <= held[0].rec.tag;
      out_rank_q <= rank_q;
      out_ovf_q  <= ovf_q;
      out_last_q <= !held[1].valid;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_rank_q, out_tag_q};
  assign m_axis_tuser  = out_ovf_q;
  assign m_axis_tlast  = out_last_q;

endmodule

[sv/hcfq_checker.sv]
module hcfq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // a waiting result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn under stall");

  // the last track of a set closes the input while the chain settles
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input open after last track");

  // results of one set leave back to back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("gap inside a sorted run");

  // ranks count up by one inside a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast
      |=> m_axis_tdata[21:16] == $past(m_axis_tdata[21:16]) + 6'd1)
    else $error("rank not consecutive");

endmodule

bind hit_count_then_fit_quality_sort_top hcfq_checker u_hcfq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
